>>> hdl/p5smg_pkg.sv
// Shared constants, control word and status types, and the microcode table
// of the power-of-five multiplier generator. No dependencies.
package p5smg_pkg;

  localparam int WORK_WORDS  = 16;
  localparam int INDEX_COUNT = 342;
  localparam int WORK_BITS   = 64 * WORK_WORDS;
  localparam int LEN_NAT     = $clog2(WORK_BITS + 1);
  localparam int LEN_W       = (LEN_NAT > 11) ? LEN_NAT : 11;
  localparam int WP_W        = $clog2(WORK_WORDS);
  localparam int IDX_W       = 9;
  localparam int CFG_W       = 7;
  localparam int RES_W       = 128;
  localparam int PC_W        = 4;

  localparam logic CFG_FWD_BITS = 1'b0;
  localparam logic CFG_INV_BITS = 1'b1;
  localparam logic CMD_INV      = 1'b0;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_SCAN, OP_FWD_PREP, OP_SHR, OP_FWD_FIN,
    OP_INV_PREP, OP_DIV, OP_INC
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_START, C_CNT_NZ, C_WORD_ZERO, C_CMD_INV, C_FWD_WIDE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic word_zero;
    logic cmd_inv;
    logic fwd_wide;
  } stat_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL      = 4'd1;
  localparam logic [PC_W-1:0] PC_SCAN     = 4'd2;
  localparam logic [PC_W-1:0] PC_FWD_PREP = 4'd3;
  localparam logic [PC_W-1:0] PC_SHR      = 4'd4;
  localparam logic [PC_W-1:0] PC_FWD_FIN  = 4'd5;
  localparam logic [PC_W-1:0] PC_INV_PREP = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV      = 4'd7;
  localparam logic [PC_W-1:0] PC_INC      = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd9;

  // A taken condition jumps to the target, otherwise the step counter advances.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:     w = '{op: OP_LOAD,     cond: C_NO_START,  target: PC_IDLE};
      PC_MUL:      w = '{op: OP_MUL,      cond: C_CNT_NZ,    target: PC_MUL};
      PC_SCAN:     w = '{op: OP_SCAN,     cond: C_WORD_ZERO, target: PC_SCAN};
      PC_FWD_PREP: w = '{op: OP_FWD_PREP, cond: C_CMD_INV,   target: PC_INV_PREP};
      PC_SHR:      w = '{op: OP_SHR,      cond: C_FWD_WIDE,  target: PC_SHR};
      PC_FWD_FIN:  w = '{op: OP_FWD_FIN,  cond: C_ALWAYS,    target: PC_EMIT};
      PC_INV_PREP: w = '{op: OP_INV_PREP, cond: C_NEVER,     target: PC_IDLE};
      PC_DIV:      w = '{op: OP_DIV,      cond: C_CNT_NZ,    target: PC_DIV};
      PC_INC:      w = '{op: OP_INC,      cond: C_NEVER,     target: PC_IDLE};
      PC_EMIT:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PC_IDLE};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/pow5_split_multiplier_gen_top.sv
// Power-of-five multiplier generator: step counter, microcode sequencing,
// configuration registers. Uses p5smg_pkg and p5smg_dp.
// An accepted item runs multiply steps, then scan steps, then either forward
// shift steps or division steps before the result strobe.
// One item at a time; busy stays high until the result strobe, and the
// result cannot be stalled. Reset clears the step counter and sets both registers to 125.
module pow5_split_multiplier_gen_top
  import p5smg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output logic              done_o,
  output logic [63:0]       value_low_o,
  output logic [61:0]       value_high_o,
  output logic [10:0]       pow_length_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CFG_W-1:0] fwd_bits_q, inv_bits_q;
  logic             done_q;
  ctrl_t            ctrl;
  op_e              op;
  stat_t            stat;
  logic             taken;

  assign ctrl = ucode(pc_q);
  assign busy = (pc_q != PC_IDLE);
  // The load step only fires on an accepted item.
  assign op   = (ctrl.op == OP_LOAD && !start) ? OP_NOP : ctrl.op;

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_START:  taken = ~start;
      C_CNT_NZ:    taken = stat.cnt_nz;
      C_WORD_ZERO: taken = stat.word_zero;
      C_CMD_INV:   taken = stat.cmd_inv;
      C_FWD_WIDE:  taken = stat.fwd_wide;
      default:     taken = 1'b0;
    endcase
    pc_d = taken ? ctrl.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PC_IDLE;
      done_q     <= 1'b0;
      fwd_bits_q <= CFG_W'(125);
      inv_bits_q <= CFG_W'(125);
    end else begin
      pc_q   <= pc_d;
      done_q <= (pc_q == PC_EMIT);
      if (cfg_we_i && cfg_addr_i == CFG_FWD_BITS) begin
        fwd_bits_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_addr_i == CFG_INV_BITS) begin
        inv_bits_q <= cfg_wdata_i;
      end
    end
  end

  assign done_o = done_q;

  p5smg_dp u_dp (
    .clk_i        (clk_i),
    .op_i         (op),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .fwd_bits_i   (fwd_bits_q),
    .inv_bits_i   (inv_bits_q),
    .stat_o       (stat),
    .value_low_o  (value_low_o),
    .value_high_o (value_high_o),
    .pow_length_o (pow_length_o)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while an item is in work");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not start work");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("item finished without a result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hdl/p5smg_dp.sv
// Datapath of the multiplier generator: the wide power register, the
// division remainder, the result register and the shared counter. Uses p5smg_pkg.
module p5smg_dp
  import p5smg_pkg::*;
(
  input  logic                  clk_i,
  input  op_e                   op_i,
  input  logic                  cmd_i,
  input  logic [IDX_W-1:0]      index_i,
  input  logic [CFG_W-1:0]      fwd_bits_i,
  input  logic [CFG_W-1:0]      inv_bits_i,
  output stat_t                 stat_o,
  output logic [63:0]           value_low_o,
  output logic [61:0]           value_high_o,
  output logic [10:0]           pow_length_o
);

  logic [WORK_BITS-1:0] p_q, p_d, r_q, r_d;
  logic [RES_W-1:0]     q_q, q_d;
  logic [LEN_W-1:0]     len_q, len_d, ctr_q, ctr_d;
  logic [WP_W-1:0]      wp_q, wp_d;
  logic                 cmd_q, cmd_d, neg_q, neg_d, first_q, first_d;

  logic [63:0]          word_sel;
  logic [6:0]           word_len;
  logic [IDX_W-1:0]     idx_sat;
  logic [LEN_W:0]       jsum;
  logic [LEN_W-1:0]     fwd_ext;
  logic [WORK_BITS-1:0] shl;
  logic [WORK_BITS:0]   diff;
  logic                 ge;
  logic [191:0]         rshift;

  // Bit length of one 64-bit word.
  function automatic logic [6:0] word_bits(input logic [63:0] w);
    logic [6:0] n;
    n = 7'd0;
    for (int b = 0; b < 64; b++) begin
      if (w[b]) begin
        n = 7'(b + 1);
      end
    end
    return n;
  endfunction

  assign word_sel = p_q[{wp_q, 6'd0} +: 64];
  assign word_len = word_bits(word_sel);
  assign idx_sat  = (index_i >= IDX_W'(INDEX_COUNT)) ? IDX_W'(INDEX_COUNT - 1) : index_i;
  assign jsum     = {1'b0, len_q} + (LEN_W+1)'(inv_bits_i) - (LEN_W+1)'(1);
  assign fwd_ext  = LEN_W'(fwd_bits_i);

  // One restoring step: the bit shifted out of the top always allows a subtract.
  assign shl    = {r_q[WORK_BITS-2:0], first_q};
  assign diff   = {r_q[WORK_BITS-1], shl} - {1'b0, p_q};
  assign ge     = ~diff[WORK_BITS];
  assign rshift = p_q[191:0] >> ctr_q[5:0];

  assign stat_o.cnt_nz    = (ctr_q != '0);
  assign stat_o.word_zero = (word_sel == 64'd0);
  assign stat_o.cmd_inv   = (cmd_q == CMD_INV);
  assign stat_o.fwd_wide  = ~neg_q && (ctr_q[LEN_W-1:6] != '0);

  always_comb begin
    p_d     = p_q;
    r_d     = r_q;
    q_d     = q_q;
    len_d   = len_q;
    ctr_d   = ctr_q;
    wp_d    = wp_q;
    cmd_d   = cmd_q;
    neg_d   = neg_q;
    first_d = first_q;
    case (op_i)
      OP_LOAD: begin
        p_d   = WORK_BITS'(1);
        ctr_d = LEN_W'(idx_sat);
        cmd_d = cmd_i;
        wp_d  = WP_W'(WORK_WORDS - 1);
      end
      OP_MUL: begin
        if (ctr_q != '0) begin
          p_d   = p_q + {p_q[WORK_BITS-3:0], 2'b00};
          ctr_d = ctr_q - LEN_W'(1);
        end
      end
      OP_SCAN: begin
        if (word_sel == 64'd0) begin
          wp_d = wp_q - WP_W'(1);
        end else begin
          len_d = LEN_W'({wp_q, 6'd0}) + LEN_W'(word_len);
        end
      end
      OP_FWD_PREP: begin
        if (len_q >= fwd_ext) begin
          ctr_d = len_q - fwd_ext;
          neg_d = 1'b0;
        end else begin
          ctr_d = fwd_ext - len_q;
          neg_d = 1'b1;
        end
      end
      OP_SHR: begin
        if (~neg_q && (ctr_q[LEN_W-1:6] != '0)) begin
          p_d   = {64'd0, p_q[WORK_BITS-1:64]};
          ctr_d = ctr_q - LEN_W'(64);
        end
      end
      OP_FWD_FIN: begin
        if (neg_q) begin
          q_d = p_q[RES_W-1:0] << ctr_q[6:0];
        end else begin
          q_d = rshift[RES_W-1:0];
        end
      end
      OP_INV_PREP: begin
        r_d     = '0;
        q_d     = '0;
        first_d = 1'b1;
        if (jsum > (LEN_W+1)'(WORK_BITS - 1)) begin
          ctr_d = LEN_W'(WORK_BITS - 1);
        end else begin
          ctr_d = jsum[LEN_W-1:0];
        end
      end
      OP_DIV: begin
        r_d     = ge ? diff[WORK_BITS-1:0] : shl;
        q_d     = {q_q[RES_W-2:0], ge};
        first_d = 1'b0;
        if (ctr_q != '0) begin
          ctr_d = ctr_q - LEN_W'(1);
        end
      end
      OP_INC: begin
        q_d = q_q + RES_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    r_q     <= r_d;
    q_q     <= q_d;
    len_q   <= len_d;
    ctr_q   <= ctr_d;
    wp_q    <= wp_d;
    cmd_q   <= cmd_d;
    neg_q   <= neg_d;
    first_q <= first_d;
  end

  assign value_low_o  = q_q[63:0];
  assign value_high_o = q_q[125:64];
  assign pow_length_o = len_q[10:0];

endmodule

>>> tb/sv/pow5_split_multiplier_gen_top_tb.sv
// Self-checking testbench for pow5_split_multiplier_gen_top: forward and inverse power-of-five
// multipliers are predicted in a scoreboard class and checked as each result strobes.
// Depends on p5smg_pkg and the pow5_split_multiplier_gen_top RTL.
module pow5_split_multiplier_gen_top_tb
  import p5smg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_FWD     = ~CMD_INV;
  localparam int   CYCLE_LIMIT = 4_000_000;
  localparam int   TAIL_CYCLES = 1500;
  localparam int   PHASES      = 8;
  localparam int   PHASE_ITEMS = 47;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] index;
    logic [63:0]      low;
    logic [61:0]      high;
    logic [10:0]      length;
  } entry_t;

  // Predicts one table entry per accepted item and checks the strobed results in order.
  class pow5_table_board;
    logic [CFG_W-1:0] fwd_bits;
    logic [CFG_W-1:0] inv_bits;
    entry_t           entry_q[$];
    int               errors;

    function new();
      fwd_bits = 7'd125;
      inv_bits = 7'd125;
      errors   = 0;
    endfunction

    function void set_regs(input logic [CFG_W-1:0] fv, input logic [CFG_W-1:0] iv);
      fwd_bits = fv;
      inv_bits = iv;
    endfunction

    function entry_t table_entry(input logic c, input logic [IDX_W-1:0] ix);
      logic [WORK_BITS-1:0] pw;
      logic [WORK_BITS-1:0] dvd;
      logic [WORK_BITS-1:0] quo;
      logic [WORK_BITS-1:0] sh;
      logic [127:0]         mult;
      int                   n;
      int                   k;
      int                   len;
      int                   s;
      int                   j;
      entry_t               e;
      n = (int'(ix) >= INDEX_COUNT) ? INDEX_COUNT - 1 : int'(ix);
      pw = '0;
      pw[0] = 1'b1;
      // Products wrap at the width of the working register.
      for (k = 0; k < n; k++) pw = (pw << 2) + pw;
      len = 0;
      for (k = 0; k < WORK_BITS; k++) if (pw[k]) len = k + 1;
      if (c == CMD_INV) begin
        j = len - 1 + int'(inv_bits);
        if (j > WORK_BITS - 1) j = WORK_BITS - 1;
        dvd = '0;
        dvd[j] = 1'b1;
        quo = dvd / pw;
        mult = quo[127:0] + 128'd1;
      end else begin
        s = len - int'(fwd_bits);
        if (s >= 0) sh = pw >> s;
        else sh = pw << (-s);
        mult = sh[127:0];
      end
      e.cmd    = c;
      e.index  = ix;
      e.low    = mult[63:0];
      e.high   = mult[125:64];
      e.length = 11'(len);
      return e;
    endfunction

    function void note_input(input logic c, input logic [IDX_W-1:0] ix);
      entry_q.push_back(table_entry(c, ix));
    endfunction

    function void check_result(input logic [63:0] lo, input logic [61:0] hi,
                               input logic [10:0] len);
      entry_t e;
      if (entry_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: low %h high %h length %0d", lo, hi, len);
        return;
      end
      e = entry_q.pop_front();
      if (lo !== e.low || hi !== e.high || len !== e.length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch cmd %0d index %0d: low %h/%h high %h/%h length %0d/%0d (exp/act)",
                   e.cmd, e.index, e.low, lo, e.high, hi, e.length, len);
      end
    endfunction

    function int pending();
      return entry_q.size();
    endfunction

    function int failures();
      return errors + entry_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic             cmd_i       = 1'b0;
  logic [IDX_W-1:0] index_i     = '0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_addr_i  = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             done_o;
  logic [63:0]      value_low_o;
  logic [61:0]      value_high_o;
  logic [10:0]      pow_length_o;

  pow5_table_board board;
  int              cycles = 0;

  pow5_split_multiplier_gen_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .value_low_o  (value_low_o),
    .value_high_o (value_high_o),
    .pow_length_o (pow_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pow5_split_multiplier_gen_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_result(value_low_o, value_high_o, pow_length_o);
  end

  // Start stays high from one item to the next, so back-to-back items need no gap.
  task automatic send_item(input logic c, input logic [IDX_W-1:0] ix);
    cmd_i   <= c;
    index_i <= ix;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_input(c, ix);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 1200)) @(posedge clk_i);
    else repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  // Always lets at least one edge pass so start is never lowered and raised in one step.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] fv, input logic [CFG_W-1:0] iv);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FWD_BITS;
    cfg_wdata_i <= fv;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_INV_BITS;
    cfg_wdata_i <= iv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_regs(fv, iv);
  endtask

  // Mostly small exponents keep the run short; the rest spans the valid range or the full field.
  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return IDX_W'($urandom_range(0, 63));
    if (r < 85) return IDX_W'($urandom_range(0, INDEX_COUNT - 1));
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  initial begin
    logic [CFG_W-1:0] fwd_set [PHASES];
    logic [CFG_W-1:0] inv_set [PHASES];
    int               idle_pct [PHASES];
    int               p;
    int               n;
    fwd_set  = '{7'd125, 7'd64, 7'd126, 7'd0, 7'd127, 7'd0, 7'd0, 7'd90};
    inv_set  = '{7'd125, 7'd64, 7'd126, 7'd127, 7'd0, 7'd0, 7'd0, 7'd70};
    idle_pct = '{0, 45, 36, 0, 45, 36, 0, 45};
    fwd_set[5] = CFG_W'($urandom_range(0, 127));
    inv_set[5] = CFG_W'($urandom_range(0, 127));
    fwd_set[6] = CFG_W'($urandom_range(64, 126));
    inv_set[6] = CFG_W'($urandom_range(64, 126));
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: smallest and largest exponents, saturating indexes, width crossings.
    send_item(CMD_FWD, 9'd0);
    send_item(CMD_INV, 9'd0);
    send_item(CMD_FWD, 9'd1);
    send_item(CMD_INV, 9'd1);
    send_item(CMD_FWD, 9'd55);
    send_item(CMD_INV, 9'd55);
    send_item(CMD_FWD, 9'd341);
    send_item(CMD_INV, 9'd341);
    send_item(CMD_FWD, 9'd511);
    send_item(CMD_INV, 9'd342);
    send_item(CMD_FWD, 9'd256);
    send_item(CMD_INV, 9'd170);

    // A zero forward width gives zero; the widest inverse truncates at index zero.
    settle();
    write_regs(7'd0, 7'd127);
    send_item(CMD_FWD, 9'd0);
    send_item(CMD_INV, 9'd0);
    send_item(CMD_FWD, 9'd341);
    send_item(CMD_INV, 9'd341);

    settle();
    write_regs(7'd127, 7'd126);
    send_item(CMD_FWD, 9'd0);
    send_item(CMD_INV, 9'd0);
    send_item(CMD_FWD, 9'd54);
    send_item(CMD_INV, 9'd341);

    settle();
    write_regs(7'd64, 7'd64);
    send_item(CMD_FWD, 9'd27);
    send_item(CMD_INV, 9'd27);
    send_item(CMD_FWD, 9'd28);
    send_item(CMD_INV, 9'd100);

    for (p = 0; p < PHASES; p++) begin
      settle();
      write_regs(fwd_set[p], inv_set[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 5) settle();
        else if ($urandom_range(0, 99) < idle_pct[p]) hold_off();
        send_item(1'($urandom_range(0, 1)), pick_index());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.failures() == 0) begin
      $display("pow5_split_multiplier_gen_top_tb: clean");
    end else begin
      $display("pow5_split_multiplier_gen_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/p5smg_pkg.sv
hdl/p5smg_dp.sv
hdl/pow5_split_multiplier_gen_top.sv
tb/sv/pow5_split_multiplier_gen_top_tb.sv
